// ----- src/eeprom_page_write_scheduler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// eeprom page write scheduler assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef EEPROM_PAGE_WRITE_SCHEDULER_UNIT_DEFINES_SVH
`define EEPROM_PAGE_WRITE_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define EPWS_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("epws assertion failed");
`define EPWS_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("epws assertion failed");
`else
`define EPWS_ASSERT_IMP(name, clk, rst_n, pre, post)
`define EPWS_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

// ----- src/epws_pkg.sv -----
// ----------------------------------------------------------------------------
// epws_pkg
// types and constants of the eeprom page write scheduler
// ----------------------------------------------------------------------------
package epws_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int PAGE_BYTES      = 64;
  localparam int PAGE_SH         = $clog2(PAGE_BYTES);
  localparam int LEN_W           = 7;
  localparam int SLOT_W          = 3;

  localparam logic [15:0] MAX_COUNT  = 16'd32768;
  localparam logic [7:0]  WAIT_RESET = 8'd11;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic [1:0] KIND_CHUNK  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] start_addr;
    logic [15:0] byte_count;
  } epws_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [14:0]       chunk_addr;
    logic [14:0]       data_offset;
    logic [LEN_W-1:0]  chunk_len;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } epws_res_t;

  typedef struct packed {
    logic [14:0] start_addr;
    logic [15:0] byte_count;
  } epws_entry_t;

endpackage

// ----- src/epws_queue.sv -----
// ----------------------------------------------------------------------------
// epws_queue
// request queue storage, one write port, registered head and next-head reads
// ----------------------------------------------------------------------------
module epws_queue #(
  parameter int QUEUE_DEPTH = epws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
  input  epws_pkg::epws_entry_t          wdata,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
  output epws_pkg::epws_entry_t          head_entry,
  output epws_pkg::epws_entry_t          next_entry
);
  import epws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  epws_entry_t            mem [QUEUE_DEPTH];
  epws_entry_t            head_r;
  epws_entry_t            next_r;
  logic       [PTR_W-1:0] naddr;

  assign naddr = (raddr == '0) ? PTR_W'(QUEUE_DEPTH - 1) : raddr - 1'b1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    head_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    next_r <= (we && waddr == naddr) ? wdata : mem[naddr];
  end

  assign head_entry = head_r;
  assign next_entry = next_r;

endmodule

// ----- src/epws_core.sv -----
// ----------------------------------------------------------------------------
// epws_core
// queue pointers, chunk arithmetic, ack/tick sequencing and result registers
// ----------------------------------------------------------------------------
`include "eeprom_page_write_scheduler_unit_defines.svh"

module epws_core #(
  parameter int QUEUE_DEPTH = epws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  epws_pkg::epws_req_t            in_req,
  input  logic [7:0]                     ticks,
  output logic                           q_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] q_waddr,
  output epws_pkg::epws_entry_t          q_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] q_raddr,
  input  epws_pkg::epws_entry_t          q_head,
  input  epws_pkg::epws_entry_t          q_next,
  output logic                           stall,
  output logic                           out_valid,
  output epws_pkg::epws_res_t            out_res
);
  import epws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             active_r, active_nxt;
  logic [15:0]      done_r, done_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [7:0]       wait_r, wait_nxt;
  logic             out_valid_r;
  epws_res_t        out_r;
  logic             pend_valid_r;
  epws_res_t        pend_r;

  logic             proc;
  logic [1:0]       nres;
  epws_res_t        res0, res1;
  logic [15:0]      sat_cnt;
  logic [16:0]      ack_sum;
  logic [OCC_W-1:0] occ_dec;

  function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic epws_res_t chunk_cmd(input logic [14:0] base,
                                          input logic [15:0] cnt,
                                          input logic [15:0] done);
    logic [14:0]      addr;
    logic [15:0]      remain;
    logic [LEN_W-1:0] room;
    epws_res_t        r;
    addr   = base + done[14:0];
    remain = (cnt > done) ? cnt - done : 16'd0;
    room   = LEN_W'(PAGE_BYTES) - LEN_W'(addr[PAGE_SH-1:0]);
    r             = '0;
    r.kind        = KIND_CHUNK;
    r.chunk_addr  = addr;
    r.data_offset = done[14:0];
    r.chunk_len   = (remain < 16'(room)) ? remain[LEN_W-1:0] : room;
    r.last        = 1'b1;
    return r;
  endfunction

  assign proc    = in_valid && !pend_valid_r;
  assign sat_cnt = (in_req.byte_count > MAX_COUNT) ? MAX_COUNT : in_req.byte_count;
  assign ack_sum = {1'b0, done_r} + 17'(plen_r);
  assign occ_dec = occ_r - 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    active_nxt = active_r;
    done_nxt   = done_r;
    plen_nxt   = plen_r;
    wait_nxt   = wait_r;
    nres       = 2'd0;
    res0       = '0;
    res1       = '0;
    q_we       = 1'b0;
    q_waddr    = wr_ptr_r;
    q_wdata    = '{start_addr: in_req.start_addr, byte_count: sat_cnt};
    if (proc) begin
      unique case (in_req.action)
        ACT_ENQUEUE: begin
          if (occ_r >= OCC_W'(QUEUE_DEPTH)) begin
            res0.kind = KIND_REJECT;
            res0.slot = SLOT_W'(wr_ptr_r);
            res0.last = 1'b1;
            nres      = 2'd1;
          end else begin
            q_we       = 1'b1;
            wr_ptr_nxt = ptr_down(wr_ptr_r);
            occ_nxt    = occ_r + 1'b1;
            if (!active_r) begin
              active_nxt = 1'b1;
              done_nxt   = 16'd0;
              res0       = chunk_cmd(in_req.start_addr, sat_cnt, 16'd0);
              res0.slot  = SLOT_W'(wr_ptr_r);
              plen_nxt   = res0.chunk_len;
              wait_nxt   = 8'd0;
              nres       = 2'd1;
            end
          end
        end
        ACT_ACK: begin
          if (active_r && wait_r == 8'd0) begin
            done_nxt = (ack_sum > 17'(MAX_COUNT)) ? MAX_COUNT : ack_sum[15:0];
            plen_nxt = '0;
            wait_nxt = (ticks == 8'd0) ? 8'd1 : ticks;
          end
        end
        ACT_TICK: begin
          if (active_r && wait_r != 8'd0) begin
            wait_nxt = wait_r - 8'd1;
            if (wait_r == 8'd1) begin
              if (done_r < q_head.byte_count) begin
                res0      = chunk_cmd(q_head.start_addr, q_head.byte_count, done_r);
                res0.slot = SLOT_W'(rd_ptr_r);
                plen_nxt  = res0.chunk_len;
                nres      = 2'd1;
              end else begin
                rd_ptr_nxt = ptr_down(rd_ptr_r);
                occ_nxt    = occ_dec;
                done_nxt   = 16'd0;
                plen_nxt   = '0;
                active_nxt = 1'b0;
                res0.kind  = KIND_DONE;
                res0.slot  = SLOT_W'(rd_ptr_r);
                res0.last  = 1'b1;
                nres       = 2'd1;
                if (occ_dec != '0) begin
                  res0.last  = 1'b0;
                  active_nxt = 1'b1;
                  res1       = chunk_cmd(q_next.start_addr, q_next.byte_count, 16'd0);
                  res1.slot  = SLOT_W'(ptr_down(rd_ptr_r));
                  plen_nxt   = res1.chunk_len;
                  nres       = 2'd2;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_raddr = rd_ptr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      occ_r        <= '0;
      active_r     <= 1'b0;
      done_r       <= 16'd0;
      plen_r       <= '0;
      wait_r       <= 8'd0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
      active_r <= active_nxt;
      done_r   <= done_nxt;
      plen_r   <= plen_nxt;
      wait_r   <= wait_nxt;
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= (nres != 2'd0);
        pend_valid_r <= (nres == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r) begin
      out_r <= pend_r;
    end else begin
      out_r  <= res0;
      pend_r <= res1;
    end
  end

  assign stall     = pend_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  `EPWS_ASSERT_IMP(a_pend_behind_out, clk, rst_n, pend_valid_r, out_valid_r)
  `EPWS_ASSERT_NXT(a_pend_drains, clk, rst_n, pend_valid_r, out_valid_r && !pend_valid_r)
  `EPWS_ASSERT_IMP(a_pend_is_chunk, clk, rst_n, pend_valid_r, pend_r.kind == KIND_CHUNK && pend_r.last)
  `EPWS_ASSERT_IMP(a_active_has_entry, clk, rst_n, active_r, occ_r != '0)
  `EPWS_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH))
  `EPWS_ASSERT_IMP(a_wait_when_active, clk, rst_n, wait_r != 8'd0, active_r)

endmodule

// ----- src/eeprom_page_write_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// eeprom_page_write_scheduler_unit
// queues eeprom write requests and splits the head request into page-aligned
// chunk write commands, paced by acks and timer ticks
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; it is held in the
// input register and its results pass through the result register to
// out_res, each for exactly one cycle with out_valid high; the receiver
// cannot stall them. One request per cycle is taken, except that a tick that
// ends a request and starts the next queued one gives two results, the second
// held in a pending register; the single result port then raises busy for
// one cycle if another request waits in the input register. Queue slots live
// in a memory with registered reads of the head and next entries.
module eeprom_page_write_scheduler_unit #(
  parameter int QUEUE_DEPTH = epws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  epws_pkg::epws_req_t in_req,
  output logic                out_valid,
  output epws_pkg::epws_res_t out_res,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import epws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic             in_valid_r;
  epws_req_t        in_req_r;
  logic [7:0]       ticks_r;
  logic             stall;
  logic             accept;
  logic             q_we;
  logic [PTR_W-1:0] q_waddr;
  logic [PTR_W-1:0] q_raddr;
  epws_entry_t      q_wdata;
  epws_entry_t      q_head;
  epws_entry_t      q_next;

  assign busy   = in_valid_r && stall;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      ticks_r    <= WAIT_RESET;
    end else begin
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (!stall) begin
        in_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req_r <= in_req;
    end
  end

  epws_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .we        (q_we),
    .waddr     (q_waddr),
    .wdata     (q_wdata),
    .raddr     (q_raddr),
    .head_entry(q_head),
    .next_entry(q_next)
  );

  epws_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid_r),
    .in_req   (in_req_r),
    .ticks    (ticks_r),
    .q_we     (q_we),
    .q_waddr  (q_waddr),
    .q_wdata  (q_wdata),
    .q_raddr  (q_raddr),
    .q_head   (q_head),
    .q_next   (q_next),
    .stall    (stall),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule
